// File: hw/rtl/sorted_priority_queue_defines.svh
// Assertion macros shared by the sorted priority queue modules
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define SPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define SPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/spq_pkg.sv
// Package: widths, status codes and shared types of the sorted priority queue
package spq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned KEY_DIGITS  = 10;

  localparam int unsigned KEY_W = 34;
  localparam int unsigned PAY_W = 32;
  localparam int unsigned DIG_W = 4;
  localparam int unsigned ST_W  = 3;
  localparam int unsigned OCC_W = 5;

  // Result status codes
  typedef enum logic [ST_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_BADLEN   = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    capture;
    logic    do_insert;
    logic    do_remove;
    logic    emit;
    status_t code;
  } spq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_insert;
    logic len_ok;
    logic full;
    logic empty;
  } spq_stat_t;

endpackage

// File: hw/rtl/spq_ctrl.sv
// Controller: request sequencing and result code decision
`include "sorted_priority_queue_defines.svh"

module spq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  spq_pkg::spq_stat_t st,
  output spq_pkg::spq_cmd_t  cmd,
  output logic               busy
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Decode the captured request into datapath commands
  always_comb begin
    state_nxt     = state_r;
    cmd.capture   = 1'b0;
    cmd.do_insert = 1'b0;
    cmd.do_remove = 1'b0;
    cmd.emit      = 1'b0;
    cmd.code      = spq_pkg::ST_INSERTED;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
        if (st.is_insert) begin
          if (!st.len_ok) begin
            cmd.code = spq_pkg::ST_BADLEN;
          end else if (st.full) begin
            cmd.code = spq_pkg::ST_FULL;
          end else begin
            cmd.code      = spq_pkg::ST_INSERTED;
            cmd.do_insert = 1'b1;
          end
        end else begin
          if (st.empty) begin
            cmd.code = spq_pkg::ST_EMPTY;
          end else begin
            cmd.code      = spq_pkg::ST_REMOVED;
            cmd.do_remove = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r == S_EXEC);

  `SPQ_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
  `SPQ_ASSERT_NXT(a_exec_one, busy, !busy, "execute phase lasted more than one cycle")
  `SPQ_ASSERT_IMP(a_one_op, cmd.do_insert || cmd.do_remove, cmd.emit && !(cmd.do_insert && cmd.do_remove), "conflicting queue operations")

endmodule

// File: hw/rtl/spq_dp.sv
// Datapath: request register, row of compare-and-shift cells, result register
`include "sorted_priority_queue_defines.svh"

module spq_dp #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_req_type,
  input  logic [spq_pkg::KEY_W-1:0] in_key,
  input  logic [spq_pkg::DIG_W-1:0] in_key_digits,
  input  logic [spq_pkg::PAY_W-1:0] in_payload,
  input  spq_pkg::spq_cmd_t         cmd,
  output spq_pkg::spq_stat_t        st,
  output logic                      out_valid,
  output logic [spq_pkg::ST_W-1:0]  out_status,
  output logic [spq_pkg::KEY_W-1:0] out_key,
  output logic [spq_pkg::PAY_W-1:0] out_payload,
  output logic [spq_pkg::OCC_W-1:0] out_occupancy
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Captured request
  logic                      req_type_r;
  logic [spq_pkg::KEY_W-1:0] req_key_r;
  logic [spq_pkg::DIG_W-1:0] req_digits_r;
  logic [spq_pkg::PAY_W-1:0] req_pay_r;

  // Entry cells, slot 0 holds the smallest key
  logic [spq_pkg::KEY_W-1:0] ekey_r [QUEUE_DEPTH];
  logic [spq_pkg::PAY_W-1:0] epay_r [QUEUE_DEPTH];
  logic [spq_pkg::KEY_W-1:0] ekey_nxt [QUEUE_DEPTH];
  logic [spq_pkg::PAY_W-1:0] epay_nxt [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]    le;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  logic                      out_valid_r;
  logic [spq_pkg::ST_W-1:0]  out_status_r;
  logic [spq_pkg::KEY_W-1:0] out_key_r;
  logic [spq_pkg::PAY_W-1:0] out_pay_r;
  logic [spq_pkg::OCC_W-1:0] out_occ_r;

  // Hold the request beat
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_type_r   <= in_req_type;
      req_key_r    <= in_key;
      req_digits_r <= in_key_digits;
      req_pay_r    <= in_payload;
    end
  end

  // Report request and fill status to the controller
  always_comb begin
    st.is_insert = ~req_type_r;
    st.len_ok    = ({1'b0, req_digits_r} == 5'(spq_pkg::KEY_DIGITS));
    st.full      = (count_r == CNT_W'(QUEUE_DEPTH));
    st.empty     = (count_r == '0);
  end

  // Each cell compares itself with the new key and picks keep, load or shift
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign le[i] = (CNT_W'(i) < count_r) && (ekey_r[i] <= req_key_r);

    always_comb begin
      ekey_nxt[i] = ekey_r[i];
      epay_nxt[i] = epay_r[i];
      if (cmd.do_insert) begin
        if (!le[i]) begin
          ekey_nxt[i] = req_key_r;
          epay_nxt[i] = req_pay_r;
        end
      end
    end

    if (i == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (cmd.do_remove && (QUEUE_DEPTH > 1)) begin
          ekey_r[i] <= ekey_r[(i + 1) % QUEUE_DEPTH];
          epay_r[i] <= epay_r[(i + 1) % QUEUE_DEPTH];
        end else begin
          ekey_r[i] <= ekey_nxt[i];
          epay_r[i] <= epay_nxt[i];
        end
      end
    end else if (i == QUEUE_DEPTH - 1) begin : g_tail
      always_ff @(posedge clk) begin
        if (cmd.do_insert && !le[i] && !le[i-1]) begin
          ekey_r[i] <= ekey_r[i-1];
          epay_r[i] <= epay_r[i-1];
        end else begin
          ekey_r[i] <= ekey_nxt[i];
          epay_r[i] <= epay_nxt[i];
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (cmd.do_remove) begin
          ekey_r[i] <= ekey_r[i+1];
          epay_r[i] <= epay_r[i+1];
        end else if (cmd.do_insert && !le[i] && !le[i-1]) begin
          ekey_r[i] <= ekey_r[i-1];
          epay_r[i] <= epay_r[i-1];
        end else begin
          ekey_r[i] <= ekey_nxt[i];
          epay_r[i] <= epay_nxt[i];
        end
      end
    end
  end

  // Advance the fill count
  always_comb begin
    count_nxt = count_r;
    if (cmd.do_insert) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.do_remove) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  // Register the result beat
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.code;
      out_key_r    <= cmd.do_remove ? ekey_r[0] : '0;
      out_pay_r    <= cmd.do_remove ? epay_r[0] : '0;
      out_occ_r    <= spq_pkg::OCC_W'(count_nxt);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_key       = out_key_r;
  assign out_payload   = out_pay_r;
  assign out_occupancy = out_occ_r;

  `SPQ_ASSERT_IMP(a_cnt_bound, 1'b1, count_r <= CNT_W'(QUEUE_DEPTH), "fill count past queue depth")
  `SPQ_ASSERT_IMP(a_no_full_ins, cmd.do_insert, count_r < CNT_W'(QUEUE_DEPTH), "insert into full queue")
  `SPQ_ASSERT_IMP(a_head_sorted, count_r >= CNT_W'(2), ekey_r[0] <= ekey_r[1], "head entries out of order")

endmodule

// File: hw/rtl/sorted_priority_queue.sv
// Sorted priority queue: a request is taken when start is high and busy is low.
// The request registers capture the accepted beat; at the edge after the accepting edge
// the cell row is updated and out_valid rises with the registered result beat.
// busy is high in the update cycle of the compare-and-shift cell row, so no new
// request is taken until the last one has updated the queue.
// Reset: synchronous active-low rst_n empties the queue and clears control state;
// entry cells are not cleared. Results cannot be stalled by the receiver.
module sorted_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_req_type,
  input  logic [spq_pkg::KEY_W-1:0] in_key,
  input  logic [spq_pkg::DIG_W-1:0] in_key_digits,
  input  logic [spq_pkg::PAY_W-1:0] in_payload,
  output logic                      out_valid,
  output logic [spq_pkg::ST_W-1:0]  out_status,
  output logic [spq_pkg::KEY_W-1:0] out_key,
  output logic [spq_pkg::PAY_W-1:0] out_payload,
  output logic [spq_pkg::OCC_W-1:0] out_occupancy
);

  spq_pkg::spq_cmd_t  cmd;
  spq_pkg::spq_stat_t st;

  spq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  spq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_req_type   (in_req_type),
    .in_key        (in_key),
    .in_key_digits (in_key_digits),
    .in_payload    (in_payload),
    .cmd           (cmd),
    .st            (st),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_key       (out_key),
    .out_payload   (out_payload),
    .out_occupancy (out_occupancy)
  );

endmodule
